// ----- hw/rtl/pcf_pkg.sv -----
// shared types, byte constants and helpers for the printer command framer
`default_nettype none
package pcf_pkg;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_FIELD = 2'd1,
        OP_DATA  = 2'd2,
        OP_END   = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [6:0] seq;
    } t_cmd;

    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_FS  = 8'h1C;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] SEQ_LO   = 8'h20;
    localparam logic [7:0] SEQ_HI   = 8'h7F;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    localparam int unsigned STEPW = 3;

    // index of the final output byte for each operation
    function automatic logic [STEPW-1:0] last_step(input t_op op);
        logic [STEPW-1:0] s;
        unique case (op)
            OP_BEGIN: s = 3'd2;
            OP_FIELD: s = 3'd0;
            OP_DATA:  s = 3'd0;
            OP_END:   s = 3'd4;
            default:  s = 3'd0;
        endcase
        return s;
    endfunction

    // upper-case ascii hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] d;
        if (v < 4'd10) begin
            d = 8'h30 + {4'd0, v};
        end else begin
            d = 8'h41 + {4'd0, v} - 8'd10;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pcf_front.sv -----
// front end: takes items, classifies them and issues frame sequence bytes
`default_nettype none
module pcf_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_q_full,
    output logic             o_q_push,
    output pcf_pkg::t_cmd    o_q_cmd
);
    import pcf_pkg::*;

    logic [6:0] r_seq;
    logic [6:0] n_seq;
    logic [7:0] seq_inc;
    t_op        op;

    assign op       = t_op'(i_operation);
    assign o_q_push = i_push && !i_q_full;
    assign seq_inc  = {1'b0, r_seq} + 8'd1;

    always_comb begin
        n_seq = r_seq;
        if (o_q_push && op == OP_BEGIN) begin
            if (seq_inc < SEQ_LO || seq_inc > SEQ_HI) begin
                n_seq = SEQ_LO[6:0];
            end else begin
                n_seq = seq_inc[6:0];
            end
        end
    end

    always_comb begin
        o_q_cmd.op   = op;
        o_q_cmd.data = i_data_byte;
        o_q_cmd.seq  = n_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= 7'd0;
        end else begin
            r_seq <= n_seq;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/pcf_queue.sv -----
// short command queue between the front and back ends
`default_nettype none
module pcf_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  pcf_pkg::t_cmd    i_cmd,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_valid,
    output pcf_pkg::t_cmd    o_cmd
);
    import pcf_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/pcf_back.sv -----
// back end: expands commands into frame bytes, keeps the sum, holds the output item
`default_nettype none
module pcf_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  pcf_pkg::t_cmd    i_q_cmd,
    output logic             o_q_pop,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [7:0]       o_out_byte,
    output logic             o_last
);
    import pcf_pkg::*;

    logic [STEPW-1:0] r_step;
    logic [STEPW-1:0] n_step;
    logic [15:0]      r_sum;
    logic [15:0]      n_sum;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [7:0]       r_out_byte;
    logic [7:0]       n_out_byte;
    logic             r_out_last;
    logic             n_out_last;
    logic             load;
    logic             final_step;
    logic [7:0]       gen_byte;
    logic [3:0]       nib;

    assign load       = i_q_valid && (!r_out_valid || i_pop);
    assign final_step = (r_step == last_step(i_q_cmd.op));
    assign o_q_pop    = load && final_step;

    always_comb begin
        unique case (r_step)
            3'd1:    nib = r_sum[15:12];
            3'd2:    nib = r_sum[11:8];
            3'd3:    nib = r_sum[7:4];
            default: nib = r_sum[3:0];
        endcase
    end

    always_comb begin
        gen_byte = i_q_cmd.data;
        n_sum    = r_sum;
        unique case (i_q_cmd.op)
            OP_BEGIN: begin
                if (r_step == '0) begin
                    gen_byte = BYTE_STX;
                    n_sum    = {8'd0, BYTE_STX};
                end else if (r_step == 3'd1) begin
                    gen_byte = {1'b0, i_q_cmd.seq};
                    n_sum    = r_sum + {8'd0, gen_byte};
                end else begin
                    gen_byte = i_q_cmd.data;
                    n_sum    = r_sum + {8'd0, gen_byte};
                end
            end
            OP_FIELD: begin
                gen_byte = BYTE_FS;
                n_sum    = r_sum + {8'd0, BYTE_FS};
            end
            OP_DATA: begin
                gen_byte = i_q_cmd.data;
                n_sum    = r_sum + {8'd0, i_q_cmd.data};
            end
            OP_END: begin
                if (r_step == '0) begin
                    gen_byte = BYTE_ETX;
                    n_sum    = r_sum + {8'd0, BYTE_ETX};
                end else begin
                    // checksum digits read the held sum, cleared after the fourth
                    gen_byte = hex_digit(nib);
                    n_sum    = final_step ? 16'd0 : r_sum;
                end
            end
            default: begin
                gen_byte = i_q_cmd.data;
                n_sum    = r_sum;
            end
        endcase
    end

    always_comb begin
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid = 1'b1;
            n_out_byte  = gen_byte;
            n_out_last  = (i_q_cmd.op == OP_END) && final_step;
            n_step      = final_step ? '0 : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_sum       <= load ? n_sum : r_sum;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule
`default_nettype wire

// ----- hw/rtl/printer_command_framer_unit.sv -----
// top level of the printer command framer
`default_nettype none
// Framer for STX/ETX printer command frames with a 16-bit byte-sum checksum
// sent as four upper-case hex digits. Items go in through a queue-style
// push/full port and frame bytes come out through empty/pop, one byte per
// result item. An item is accepted whenever the four-entry command queue has
// room; the output side then produces one byte per cycle while the consumer
// keeps popping, so a data or field item yields one byte, begin three and end
// five. The back end's single byte generator is what sets that rate. There is
// no startup pass after reset; the first frame uses sequence byte 0x20.
module printer_command_framer_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_data_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_last
);
    import pcf_pkg::*;

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_cmd q_in_cmd;
    t_cmd q_out_cmd;

    assign full = q_full;

    pcf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in_cmd)
    );

    pcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    pcf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_out_cmd),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/pcf_checker.sv -----
// port-level checks for the printer command framer
`default_nettype none
module pcf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic [1:0] i_operation,
    input wire logic [7:0] i_data_byte,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last
);

    // nothing is waiting on the output right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("output not empty after reset");

    // the closing item is always a hex digit of the checksum
    a_last_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |->
            ((o_out_byte >= 8'h30 && o_out_byte <= 8'h39) ||
             (o_out_byte >= 8'h41 && o_out_byte <= 8'h46)))
        else $error("last item is not a hex digit");

    // an item that is not taken stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_last)))
        else $error("waiting output item changed");

    // the item after a last digit opens something new and is never last itself
    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_last) |=> (empty || !o_last))
        else $error("last flag repeated");

    // an accepted item carries known fields and leaves the output non-empty
    a_push_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |-> (!$isunknown({i_operation, i_data_byte}) ##2 !empty))
        else $error("accepted item did not reach the output");

endmodule

bind printer_command_framer_unit pcf_checker u_pcf_checker (.*);
`default_nettype wire
